// ===== src/p2spi_pkg.sv =====
// Package for the parallel-to-SPI command decoder.
// Holds phase and action codes, command byte constants and payload types.
// No dependencies.
`default_nettype none

package p2spi_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN2 = 3'd1,
        PH_XFER = 3'd2,
        PH_PIN  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SEL   = 3'd1,
        ACT_DESEL = 3'd2,
        ACT_PIN   = 3'd3,
        ACT_SPEED = 3'd4,
        ACT_WRITE = 3'd5,
        ACT_READ  = 3'd6,
        ACT_ERR   = 3'd7
    } t_action;

    // host event kinds
    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_CLK   = 2'd1;
    localparam logic [1:0] KIND_REL   = 2'd2;

    // special command bytes
    localparam logic [7:0] CMD_DESEL  = 8'hc0;
    localparam logic [7:0] CMD_SEL    = 8'hc1;
    localparam logic [7:0] CMD_PIN    = 8'hc2;
    localparam logic [7:0] CMD_SLOW   = 8'hc4;
    localparam logic [7:0] CMD_FAST   = 8'hc5;

    typedef struct packed {
        t_action    action;
        logic [7:0] out_byte;
        logic       active;
        logic       last;
        logic       chip_select;
        logic       fast_mode;
    } t_result;

endpackage

`default_nettype wire

// ===== src/p2spi_if.sv =====
// Valid/ready channel interfaces for the parallel-to-SPI command decoder.
// p2spi_in_if carries host events, p2spi_out_if carries decode results.
// No dependencies.
`default_nettype none

interface p2spi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic       card_detect;

    modport source (output valid, output kind, output bus_byte, output card_detect,
                    input ready);
    modport sink   (input valid, input kind, input bus_byte, input card_detect,
                    output ready);
endinterface

interface p2spi_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] out_byte;
    logic       active;
    logic       last;
    logic       chip_select;
    logic       fast_mode;

    modport source (output valid, output action, output out_byte, output active,
                    output last, output chip_select, output fast_mode, input ready);
    modport sink   (input valid, input action, input out_byte, input active,
                    input last, input chip_select, input fast_mode, output ready);
endinterface

`default_nettype wire

// ===== src/parallel_to_spi_command_decoder_top.sv =====
// Top level of the parallel-to-SPI command decoder.
// Depends on p2spi_pkg and the channel interfaces in p2spi_if.sv.
// Decodes host port events into SPI byte requests and control actions.
`default_nettype none

// Each host event (request with command byte, clock toggle, request release)
// is one input transaction and yields exactly one result transaction.
// Throughput is one transaction per clock while the sink takes each result; the
// result register follows the single decode stage. Outside reset the
// input side stays ready whenever the result register is empty or is being
// taken in the same cycle, so a stalled sink holds at most one finished result.
// Short commands carry a 6-bit length (1..64 bytes); long commands take a
// second byte holding the read flag and the 7 low length bits, and the low
// LENGTH_BITS-7 bits of the first byte are kept as the top length bits.
// The byte counter is LENGTH_BITS+1 bits wide.
// Unknown commands and events out of phase report the error action.

module parallel_to_spi_command_decoder_top
    import p2spi_pkg::*;
#(
    parameter int LENGTH_BITS = 13
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    p2spi_in_if.sink    i_in,
    p2spi_out_if.source o_out
);

    localparam int CntW  = LENGTH_BITS + 1;
    localparam int HighW = LENGTH_BITS - 7;
    localparam logic [5:0] HighMask = 6'((1 << HighW) - 1);

    // decoder state
    t_phase          r_phase,       n_phase;
    logic [CntW-1:0] r_bytes_left,  n_bytes_left;
    logic [5:0]      r_length_high, n_length_high;
    logic            r_is_read,     n_is_read;
    logic            r_selected,    n_selected;
    logic            r_speed_fast,  n_speed_fast;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic w_accept;
    logic [13:0] w_long_len;

    // no transaction is taken while reset is held
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    // long length: masked high bits above the 7 low bits of the second byte
    assign w_long_len = {r_length_high & HighMask, i_in.bus_byte[6:0]} + 14'd1;

    // next state and result for one event
    always_comb begin
        t_action    act;
        logic [7:0] ob;
        logic       lst;
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_length_high = r_length_high;
        n_is_read     = r_is_read;
        n_selected    = r_selected;
        n_speed_fast  = r_speed_fast;
        act = ACT_NONE;
        ob  = 8'd0;
        lst = 1'b0;
        case (i_in.kind)
            KIND_REQ: begin
                if (r_phase != PH_IDLE) begin
                    // request while a command is held aborts it
                    act          = ACT_ERR;
                    n_phase      = PH_IDLE;
                    n_bytes_left = '0;
                end else if (!i_in.bus_byte[7]) begin
                    n_bytes_left = CntW'({2'b00, i_in.bus_byte[5:0]} + 8'd1);
                    n_is_read    = i_in.bus_byte[6];
                    n_phase      = PH_XFER;
                end else if (!i_in.bus_byte[6]) begin
                    n_length_high = i_in.bus_byte[5:0];
                    n_phase       = PH_LEN2;
                end else if (i_in.bus_byte == CMD_DESEL) begin
                    n_selected = 1'b0;
                    act        = ACT_DESEL;
                    n_phase    = PH_DONE;
                end else if (i_in.bus_byte == CMD_SEL) begin
                    n_selected = 1'b1;
                    act        = ACT_SEL;
                    n_phase    = PH_DONE;
                end else if (i_in.bus_byte == CMD_PIN) begin
                    n_phase = PH_PIN;
                end else if (i_in.bus_byte == CMD_SLOW || i_in.bus_byte == CMD_FAST) begin
                    n_speed_fast = i_in.bus_byte[0];
                    act          = ACT_SPEED;
                    ob           = {7'd0, i_in.bus_byte[0]};
                    n_phase      = PH_DONE;
                end else begin
                    act = ACT_ERR;
                end
            end
            KIND_CLK: begin
                case (r_phase)
                    PH_LEN2: begin
                        n_bytes_left = CntW'(w_long_len);
                        n_is_read    = i_in.bus_byte[7];
                        n_phase      = PH_XFER;
                    end
                    PH_XFER: begin
                        if (r_is_read) begin
                            act = ACT_READ;
                        end else begin
                            act = ACT_WRITE;
                            ob  = i_in.bus_byte;
                        end
                        if (r_bytes_left != '0) begin
                            n_bytes_left = r_bytes_left - CntW'(1);
                        end
                        if (n_bytes_left == '0) begin
                            lst     = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_PIN: begin
                        act     = ACT_PIN;
                        ob      = {7'd0, i_in.card_detect};
                        n_phase = PH_DONE;
                    end
                    default: begin
                        act = ACT_ERR;
                    end
                endcase
            end
            KIND_REL: begin
                if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                    act = ACT_ERR;
                end
                n_phase      = PH_IDLE;
                n_bytes_left = '0;
            end
            default: begin
                // undefined event kind: no effect
            end
        endcase
        n_out.action      = act;
        n_out.out_byte    = ob;
        n_out.active      = (n_phase != PH_IDLE);
        n_out.last        = lst;
        n_out.chip_select = n_selected;
        n_out.fast_mode   = n_speed_fast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bytes_left  <= '0;
            r_length_high <= '0;
            r_is_read     <= 1'b0;
            r_selected    <= 1'b0;
            r_speed_fast  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase       <= n_phase;
                r_bytes_left  <= n_bytes_left;
                r_length_high <= n_length_high;
                r_is_read     <= n_is_read;
                r_selected    <= n_selected;
                r_speed_fast  <= n_speed_fast;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out.action;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.active      = r_out.active;
    assign o_out.last        = r_out.last;
    assign o_out.chip_select = r_out.chip_select;
    assign o_out.fast_mode   = r_out.fast_mode;

endmodule

`default_nettype wire

// ===== src/p2spi_assert.sv =====
// Port-level assertions for the parallel-to-SPI command decoder.
// Depends on p2spi_pkg; bound to parallel_to_spi_command_decoder_top below.
`default_nettype none

module p2spi_assert
    import p2spi_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [2:0] i_action,
    input wire [7:0] i_out_byte,
    input wire       i_last,
    input wire       i_chip_select,
    input wire       i_fast_mode
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_action)
            && $stable(i_out_byte) && $stable(i_last))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_action == ACT_WRITE || i_action == ACT_READ)
        else $error("last mark outside a byte transfer");

    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_SEL || i_action == ACT_DESEL)
            |-> i_chip_select == (i_action == ACT_SEL))
        else $error("chip select disagrees with select action");

    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action == ACT_SPEED |-> i_out_byte == {7'd0, i_fast_mode})
        else $error("speed report disagrees with speed state");

endmodule

bind parallel_to_spi_command_decoder_top p2spi_assert u_p2spi_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_action      (o_out.action),
    .i_out_byte    (o_out.out_byte),
    .i_last        (o_out.last),
    .i_chip_select (o_out.chip_select),
    .i_fast_mode   (o_out.fast_mode)
);

`default_nettype wire
